/* hdl/rounded_rect_gradient_span_macros.svh */
// assertion macros for the rounded rectangle span block
// used by the checker module only, no other dependencies
`ifndef ROUNDED_RECT_GRADIENT_SPAN_MACROS_SVH
`define ROUNDED_RECT_GRADIENT_SPAN_MACROS_SVH

// clocked check, switched off while reset is held
`define RRG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define RRG_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/rrg_pkg.sv */
// shared constants, register codes and pipeline types for the span block
// no dependencies
package rrg_pkg;

    localparam int CELL_SHIFT = 3;
    localparam int MAX_RADIUS = 63;
    localparam int EDGE_W     = 8;
    localparam int COORD_W    = EDGE_W + CELL_SHIFT;
    localparam int RAD_W      = 6;
    localparam int CH_W       = 8;
    localparam int NCH        = 3;
    localparam int COL_W      = CH_W * NCH;
    localparam int NUM_W      = COORD_W + CH_W;
    localparam int SQ_W       = 2 * RAD_W + 1;
    localparam int MODE_W     = 3;
    localparam int IDX_W      = 3;
    localparam int STEPS      = 4;

    localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SOLID    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SPLIT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GRADIENT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PYRAMID  = 3'd4;

    localparam logic [IDX_W-1:0] REG_COLOUR_A = 3'd0;
    localparam logic [IDX_W-1:0] REG_COLOUR_B = 3'd1;
    localparam logic [IDX_W-1:0] REG_MODE     = 3'd2;
    localparam logic [IDX_W-1:0] REG_RADIUS   = 3'd3;
    localparam logic [IDX_W-1:0] REG_LEFT     = 3'd4;
    localparam logic [IDX_W-1:0] REG_TOP      = 3'd5;
    localparam logic [IDX_W-1:0] REG_RIGHT    = 3'd6;
    localparam logic [IDX_W-1:0] REG_BOTTOM   = 3'd7;

    typedef struct packed {
        logic [COL_W-1:0]  colour_a;
        logic [COL_W-1:0]  colour_b;
        logic [MODE_W-1:0] fill_mode;
        logic [RAD_W-1:0]  corner_radius;
        logic [EDGE_W-1:0] area_left;
        logic [EDGE_W-1:0] area_top;
        logic [EDGE_W-1:0] area_right;
        logic [EDGE_W-1:0] area_bottom;
    } t_cfg;

    typedef struct packed {
        logic                      ok;
        logic                      corner;
        logic                      split;
        logic [COORD_W-1:0]        h;
        logic [RAD_W-1:0]          e;
        logic [COORD_W-1:0]        num;
        logic [COORD_W-1:0]        prow;
        logic [SQ_W-1:0]           sq_rem;
        logic [RAD_W-1:0]          root;
        logic [NCH-1:0][NUM_W-1:0] rem;
        logic [NCH-1:0][CH_W-1:0]  quot;
    } t_item;

    typedef struct packed {
        logic               drawn;
        logic [COORD_W-1:0] prow;
        logic [COORD_W-1:0] span_start;
        logic [COORD_W-1:0] span_end;
        logic [COL_W-1:0]   colour;
    } t_out;

endpackage

/* hdl/rounded_rect_gradient_span.sv */
// top level of the rounded rectangle row span generator
// depends on rrg_pkg, rrg_front, rrg_step, rrg_back
//
// usage
//   config: write registers over i_cfg_valid / i_cfg_index / i_cfg_data while idle;
//           o_cfg_ready is always high, so every write is accepted
//   input:  one item per row offset on the s side (i_s_tdata[10:0])
//   output: one item per input on the m side, o_m_tuser is the drawn flag,
//           o_m_tdata holds pixel row, span start, span end and colour
//   depth:  seven register stages (two front, four root/divide steps, one output
//           register)
//   throughput: one item per cycle unless the output stalls; the restoring divide of
//           the blend and the corner square root run two bits per stage, which sets the depth
//   stall: each stage keeps its item while the next one is full, so a low
//           i_m_tready fills the bubbles first and only then drops o_s_tready
//   reset: synchronous, active low; clears all valid bits and the config registers
//
module rounded_rect_gradient_span (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel, tdata: row_offset[10:0], zero padding above
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,
    // output channel, tdata: pixel_row[10:0], span_start[21:11],
    // span_end[32:22], span_colour[56:33], zero padding above
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,
    // tuser: row_drawn
    output logic        o_m_tuser,
    // register write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [rrg_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [rrg_pkg::COL_W-1:0] i_cfg_data
);

    rrg_pkg::t_cfg   r_cfg;
    rrg_pkg::t_item  w_item [0:rrg_pkg::STEPS];
    logic            w_vld  [0:rrg_pkg::STEPS];
    logic            w_rdy  [0:rrg_pkg::STEPS];
    rrg_pkg::t_out   w_out;

    // register file, written one entry per handshake
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rrg_pkg::REG_COLOUR_A: r_cfg.colour_a      <= i_cfg_data;
                rrg_pkg::REG_COLOUR_B: r_cfg.colour_b      <= i_cfg_data;
                rrg_pkg::REG_MODE:     r_cfg.fill_mode     <= i_cfg_data[rrg_pkg::MODE_W-1:0];
                rrg_pkg::REG_RADIUS:   r_cfg.corner_radius <= i_cfg_data[rrg_pkg::RAD_W-1:0];
                rrg_pkg::REG_LEFT:     r_cfg.area_left     <= i_cfg_data[rrg_pkg::EDGE_W-1:0];
                rrg_pkg::REG_TOP:      r_cfg.area_top      <= i_cfg_data[rrg_pkg::EDGE_W-1:0];
                rrg_pkg::REG_RIGHT:    r_cfg.area_right    <= i_cfg_data[rrg_pkg::EDGE_W-1:0];
                rrg_pkg::REG_BOTTOM:   r_cfg.area_bottom   <= i_cfg_data[rrg_pkg::EDGE_W-1:0];
                default: ;
            endcase
        end
    end

    // geometry and blend numerators
    rrg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (i_s_tvalid),
        .o_rdy   (o_s_tready),
        .i_row   (i_s_tdata[rrg_pkg::COORD_W-1:0]),
        .o_vld   (w_vld[0]),
        .i_rdy   (w_rdy[0]),
        .o_item  (w_item[0])
    );

    // root and divide steps, two bits each
    for (genvar g = 0; g < rrg_pkg::STEPS; g++) begin : g_step
        rrg_step #(.STEP(g)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .o_rdy   (w_rdy[g]),
            .i_item  (w_item[g]),
            .o_vld   (w_vld[g+1]),
            .i_rdy   (w_rdy[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    // inset, span ends, colour and output register
    rrg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (w_vld[rrg_pkg::STEPS]),
        .o_rdy   (w_rdy[rrg_pkg::STEPS]),
        .i_item  (w_item[rrg_pkg::STEPS]),
        .o_vld   (o_m_tvalid),
        .i_rdy   (i_m_tready),
        .o_out   (w_out)
    );

    // output packing, lowest field first
    assign o_m_tuser = w_out.drawn;
    assign o_m_tdata = {7'd0, w_out.colour, w_out.span_end, w_out.span_start, w_out.prow};

endmodule

/* hdl/rrg_front.sv */
// front stages: row geometry, then corner square term and blend numerators
// depends on rrg_pkg
module rrg_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rrg_pkg::t_cfg    i_cfg,
    input  logic             i_vld,
    output logic             o_rdy,
    input  logic [rrg_pkg::COORD_W-1:0] i_row,
    output logic             o_vld,
    input  logic             i_rdy,
    output rrg_pkg::t_item   o_item
);

    logic                         r_vld_a, r_vld_b;
    rrg_pkg::t_item               r_item_a, r_item_b, n_item_a, n_item_b;
    logic                         rdy_b;
    logic [rrg_pkg::EDGE_W-1:0]   diff;
    logic [rrg_pkg::COORD_W-1:0]  h, hm, d;
    logic [rrg_pkg::RAD_W-1:0]    rad;
    logic [rrg_pkg::COORD_W:0]    twor, h12, hr2;

    // radius clamp
    assign rad = (i_cfg.corner_radius > rrg_pkg::RAD_W'(rrg_pkg::MAX_RADIUS))
               ? rrg_pkg::RAD_W'(rrg_pkg::MAX_RADIUS) : i_cfg.corner_radius;

    always_comb begin
        diff = i_cfg.area_bottom - i_cfg.area_top;
        h    = {diff, {rrg_pkg::CELL_SHIFT{1'b0}}};
        hm   = h - rrg_pkg::COORD_W'(1) - i_row;
        d    = (i_row < hm) ? i_row : hm;
        twor = {i_row, 1'b0};
        h12  = {1'b0, h};
        hr2  = (h12 - {1'b0, i_row}) << 1;
        n_item_a        = '0;
        n_item_a.ok     = (i_cfg.fill_mode != rrg_pkg::MODE_NONE)
                        && (i_cfg.area_bottom > i_cfg.area_top) && (i_row < h);
        n_item_a.h      = h;
        n_item_a.corner = d <= rrg_pkg::COORD_W'(rad);
        n_item_a.e      = rad - d[rrg_pkg::RAD_W-1:0];
        n_item_a.split  = twor >= h12;
        if (i_cfg.fill_mode == rrg_pkg::MODE_PYRAMID) begin
            n_item_a.num = n_item_a.split ? hr2[rrg_pkg::COORD_W-1:0]
                                          : twor[rrg_pkg::COORD_W-1:0];
        end else begin
            n_item_a.num = i_row;
        end
        n_item_a.prow = {i_cfg.area_top, {rrg_pkg::CELL_SHIFT{1'b0}}} + i_row;
    end

    // square term for the corner root and per channel blend numerators
    always_comb begin
        n_item_b        = r_item_a;
        n_item_b.sq_rem = rrg_pkg::SQ_W'(rad) * rrg_pkg::SQ_W'(rad)
                        - rrg_pkg::SQ_W'(r_item_a.e) * rrg_pkg::SQ_W'(r_item_a.e);
        n_item_b.root   = '0;
        n_item_b.quot   = '0;
        for (int c = 0; c < rrg_pkg::NCH; c++) begin
            n_item_b.rem[c] =
                rrg_pkg::NUM_W'(r_item_a.num)
                * rrg_pkg::NUM_W'(i_cfg.colour_a[c*rrg_pkg::CH_W +: rrg_pkg::CH_W])
              + rrg_pkg::NUM_W'(r_item_a.h - r_item_a.num)
                * rrg_pkg::NUM_W'(i_cfg.colour_b[c*rrg_pkg::CH_W +: rrg_pkg::CH_W]);
        end
    end

    assign rdy_b = !r_vld_b || i_rdy;
    assign o_rdy = !r_vld_a || rdy_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (o_rdy) r_vld_a <= i_vld;
            if (rdy_b) r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) r_item_a <= n_item_a;
        if (rdy_b) r_item_b <= n_item_b;
    end

    assign o_vld  = r_vld_b;
    assign o_item = r_item_b;

endmodule

/* hdl/rrg_step.sv */
// one pipeline step: up to two root bits of the corner term, two quotient bits per channel
// depends on rrg_pkg
module rrg_step #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    output logic           o_rdy,
    input  rrg_pkg::t_item i_item,
    output logic           o_vld,
    input  logic           i_rdy,
    output rrg_pkg::t_item o_item
);

    localparam int RB = rrg_pkg::RAD_W - 1 - 2 * STEP;
    localparam int QB = rrg_pkg::CH_W - 1 - 2 * STEP;

    logic                        r_vld;
    rrg_pkg::t_item              r_item, n_item;
    logic [rrg_pkg::SQ_W-1:0]    trial;
    logic [rrg_pkg::NUM_W-1:0]   dsub;

    always_comb begin
        n_item = i_item;
        trial  = '0;
        dsub   = '0;
        for (int k = 0; k < 2; k++) begin
            if (RB - k >= 0) begin
                trial = (rrg_pkg::SQ_W'(n_item.root) << (RB - k + 1))
                      + (rrg_pkg::SQ_W'(1) << (2 * (RB - k)));
                if (n_item.sq_rem >= trial) begin
                    n_item.sq_rem = n_item.sq_rem - trial;
                    n_item.root[RB-k] = 1'b1;
                end
            end
            if (QB - k >= 0) begin
                dsub = rrg_pkg::NUM_W'(n_item.h) << (QB - k);
                for (int c = 0; c < rrg_pkg::NCH; c++) begin
                    if (n_item.rem[c] >= dsub) begin
                        n_item.rem[c]       = n_item.rem[c] - dsub;
                        n_item.quot[c][QB-k] = 1'b1;
                    end
                end
            end
        end
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) r_item <= n_item;
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

/* hdl/rrg_back.sv */
// last stage: corner inset, span ends, colour choice and output register
// depends on rrg_pkg
module rrg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rrg_pkg::t_cfg  i_cfg,
    input  logic           i_vld,
    output logic           o_rdy,
    input  rrg_pkg::t_item i_item,
    output logic           o_vld,
    input  logic           i_rdy,
    output rrg_pkg::t_out  o_out
);

    logic                        r_vld;
    rrg_pkg::t_out               r_out, n_out;
    logic [rrg_pkg::RAD_W-1:0]   rad, inset;
    logic [rrg_pkg::COORD_W:0]   xs, xr, sp_start, sp_end, ins1;
    logic                        fits;

    assign rad = (i_cfg.corner_radius > rrg_pkg::RAD_W'(rrg_pkg::MAX_RADIUS))
               ? rrg_pkg::RAD_W'(rrg_pkg::MAX_RADIUS) : i_cfg.corner_radius;

    always_comb begin
        inset    = i_item.corner ? rad - i_item.root : '0;
        xs       = {1'b0, i_cfg.area_left, {rrg_pkg::CELL_SHIFT{1'b0}}};
        xr       = {1'b0, i_cfg.area_right, {rrg_pkg::CELL_SHIFT{1'b0}}};
        ins1     = (rrg_pkg::COORD_W+1)'(inset) + (rrg_pkg::COORD_W+1)'(1);
        sp_start = xs + (rrg_pkg::COORD_W+1)'(inset);
        sp_end   = xr - ins1;
        fits     = (xr >= ins1) && (sp_start <= sp_end);
        n_out    = '0;
        if (i_item.ok && fits) begin
            n_out.drawn      = 1'b1;
            n_out.prow       = i_item.prow;
            n_out.span_start = sp_start[rrg_pkg::COORD_W-1:0];
            n_out.span_end   = sp_end[rrg_pkg::COORD_W-1:0];
            case (i_cfg.fill_mode)
                rrg_pkg::MODE_SPLIT:    n_out.colour = i_item.split ? i_cfg.colour_b
                                                                     : i_cfg.colour_a;
                rrg_pkg::MODE_GRADIENT: n_out.colour = i_item.quot;
                rrg_pkg::MODE_PYRAMID:  n_out.colour = i_item.quot;
                default:                n_out.colour = i_cfg.colour_a;
            endcase
        end
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) r_out <= n_out;
    end

    assign o_vld = r_vld;
    assign o_out = r_out;

endmodule

/* hdl/rrg_checker.sv */
// port level checks for the span block, bound to the top level
// depends on rounded_rect_gradient_span_macros.svh and rounded_rect_gradient_span
`include "rounded_rect_gradient_span_macros.svh"

module rrg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [15:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index,
    input logic [23:0] i_cfg_data
);

    // an undrawn row carries no span
    `RRG_ASSERT(a_undrawn_zero, (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 64'd0), "undrawn item has data")
    // input only backs up when the output is stalled
    `RRG_ASSERT(a_backpressure, !o_s_tready |-> (o_m_tvalid && !i_m_tready), "input stalled without output stall")
    // padding above the colour stays clear
    `RRG_ASSERT(a_pad_zero, o_m_tvalid |-> (o_m_tdata[63:57] == 7'd0), "padding bits set")
    // a held item stays offered
    `RRG_ASSERT(a_hold, (o_m_tvalid && !i_m_tready) |=> o_m_tvalid, "output item dropped while stalled")
    // nothing is offered right after reset
    `RRG_ASSERT_RST(a_reset_idle, $past(!i_rst_n) |-> !o_m_tvalid, "output valid after reset")

endmodule

bind rounded_rect_gradient_span rrg_checker u_rrg_checker (.*);

/* verif/tb.sv */
// self-checking testbench for the rounded rectangle row span generator
// depends on rrg_pkg and rounded_rect_gradient_span; predicts every span and colour itself
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;    // row_offset[10:0], zero padding above
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;    // pixel_row, span_start, span_end, span_colour
    logic        o_m_tuser;    // row_drawn
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [rrg_pkg::IDX_W-1:0] i_cfg_index;
    logic [rrg_pkg::COL_W-1:0] i_cfg_data;

    rounded_rect_gradient_span u_dut (.*);

    // clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // local copy of the register file
    rrg_pkg::t_cfg shadow_cfg;

    // spans still owed by the block, oldest first
    rrg_pkg::t_out pending_spans[$];
    int   n_errors;
    bit   rx_hold;          // long receiver hold-off requested
    int   idle_cycles;

    // floor square root
    function automatic int unsigned root_floor(int unsigned n);
        int unsigned k;
        k = 0;
        while ((k + 1) * (k + 1) <= n) k++;
        return k;
    endfunction

    // per-channel weighted blend of the two colours
    function automatic logic [rrg_pkg::COL_W-1:0] mix_colour(int unsigned num, int unsigned h);
        logic [rrg_pkg::COL_W-1:0] res;
        int unsigned ca, cb;
        res = '0;
        for (int c = 0; c < rrg_pkg::NCH; c++) begin
            ca = shadow_cfg.colour_a[c*rrg_pkg::CH_W +: rrg_pkg::CH_W];
            cb = shadow_cfg.colour_b[c*rrg_pkg::CH_W +: rrg_pkg::CH_W];
            res[c*rrg_pkg::CH_W +: rrg_pkg::CH_W] =
                rrg_pkg::CH_W'((num * ca + (h - num) * cb) / h);
        end
        return res;
    endfunction

    // expected span for one row offset under the current registers
    function automatic rrg_pkg::t_out predict_span(int unsigned r);
        rrg_pkg::t_out o;
        int unsigned rad, xx, yy, xr, h, d, inset, st, en;
        logic [rrg_pkg::COL_W-1:0] col;
        o = '0;
        rad = shadow_cfg.corner_radius;
        if (rad > rrg_pkg::MAX_RADIUS) rad = rrg_pkg::MAX_RADIUS;
        xx = shadow_cfg.area_left << rrg_pkg::CELL_SHIFT;
        yy = shadow_cfg.area_top << rrg_pkg::CELL_SHIFT;
        xr = shadow_cfg.area_right << rrg_pkg::CELL_SHIFT;
        if (shadow_cfg.fill_mode == rrg_pkg::MODE_NONE ||
            shadow_cfg.area_bottom <= shadow_cfg.area_top) return o;
        h = (shadow_cfg.area_bottom - shadow_cfg.area_top) << rrg_pkg::CELL_SHIFT;
        if (r >= h) return o;
        d = r;
        if (h - 1 - r < d) d = h - 1 - r;
        inset = 0;
        if (d <= rad) inset = rad - root_floor(rad * rad - (rad - d) * (rad - d));
        st = xx + inset;
        if (xr < 1 + inset) return o;
        en = xr - 1 - inset;
        if (st > en) return o;
        case (shadow_cfg.fill_mode)
            rrg_pkg::MODE_SPLIT:
                col = (2 * r >= h) ? shadow_cfg.colour_b : shadow_cfg.colour_a;
            rrg_pkg::MODE_GRADIENT: col = mix_colour(r, h);
            rrg_pkg::MODE_PYRAMID:  col = mix_colour((2 * r < h) ? 2 * r : 2 * (h - r), h);
            default:                col = shadow_cfg.colour_a;
        endcase
        o.drawn      = 1'b1;
        o.prow       = rrg_pkg::COORD_W'(yy + r);
        o.span_start = rrg_pkg::COORD_W'(st);
        o.span_end   = rrg_pkg::COORD_W'(en);
        o.colour     = col;
        return o;
    endfunction

    // random gap, mostly short with a few long ones
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // register write, only while the block is idle
    task automatic write_reg(input logic [rrg_pkg::IDX_W-1:0] idx, input int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= rrg_pkg::COL_W'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            rrg_pkg::REG_COLOUR_A: shadow_cfg.colour_a      = rrg_pkg::COL_W'(val);
            rrg_pkg::REG_COLOUR_B: shadow_cfg.colour_b      = rrg_pkg::COL_W'(val);
            rrg_pkg::REG_MODE:     shadow_cfg.fill_mode     = val[rrg_pkg::MODE_W-1:0];
            rrg_pkg::REG_RADIUS:   shadow_cfg.corner_radius = val[rrg_pkg::RAD_W-1:0];
            rrg_pkg::REG_LEFT:     shadow_cfg.area_left     = val[rrg_pkg::EDGE_W-1:0];
            rrg_pkg::REG_TOP:      shadow_cfg.area_top      = val[rrg_pkg::EDGE_W-1:0];
            rrg_pkg::REG_RIGHT:    shadow_cfg.area_right    = val[rrg_pkg::EDGE_W-1:0];
            default:               shadow_cfg.area_bottom   = val[rrg_pkg::EDGE_W-1:0];
        endcase
        // idle gap so that the next write starts in a fresh time step
        @(posedge i_clk);
    endtask

    // send one row offset; gaps only when allowed
    task automatic send_row(input int unsigned r, input bit use_gaps);
        int g;
        logic [10:0] rv;
        rv = 11'(r);
        g = use_gaps ? gap_len() : 0;
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'd0, rv};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_spans.push_back(predict_span(rv));
    endtask

    task automatic drop_valid();
        i_s_tvalid <= 1'b0;
    endtask

    // wait until every span has come back, then past the pipeline depth
    task automatic drain();
        drop_valid();
        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic load_area(input int l, input int t, input int rr, input int b,
                             input int rad, input int mode);
        write_reg(rrg_pkg::REG_LEFT, l);
        write_reg(rrg_pkg::REG_TOP, t);
        write_reg(rrg_pkg::REG_RIGHT, rr);
        write_reg(rrg_pkg::REG_BOTTOM, b);
        write_reg(rrg_pkg::REG_RADIUS, rad);
        write_reg(rrg_pkg::REG_MODE, mode);
    endtask

    // directed: edges, every mode, degenerate areas, wide coordinates
    task automatic test_directed();
        write_reg(rrg_pkg::REG_COLOUR_A, 24'hFF0000);
        write_reg(rrg_pkg::REG_COLOUR_B, 24'h00FF00);
        load_area(2, 1, 12, 5, 10, rrg_pkg::MODE_NONE);
        send_row(0, 0);
        for (int m = rrg_pkg::MODE_SOLID; m <= 7; m++) begin
            drain();
            write_reg(rrg_pkg::REG_MODE, m);
            send_row(0, 0);
            send_row(16, 0);
            send_row(31, 0);
        end
        drain();
        send_row(32, 0);          // just outside the area
        send_row(11'h7FF, 0);
        drain();
        load_area(255, 255, 255, 0, 63, rrg_pkg::MODE_GRADIENT);   // empty height
        send_row(0, 0);
        drain();
        load_area(0, 0, 1, 1, 63, rrg_pkg::MODE_SOLID);   // radius larger than the area
        send_row(0, 0);
        send_row(7, 0);
        drain();
        load_area(250, 250, 255, 255, 3, rrg_pkg::MODE_PYRAMID);   // coordinates near the top of the range
        write_reg(rrg_pkg::REG_COLOUR_A, 24'hFFFFFF);
        write_reg(rrg_pkg::REG_COLOUR_B, 24'h000000);
        send_row(0, 0);
        send_row(39, 0);
        drain();
    endtask

    // random areas and rows, plus one long receiver hold-off
    task automatic test_random();
        int h, nrows;
        for (int ph = 0; ph < 30; ph++) begin
            write_reg(rrg_pkg::REG_COLOUR_A, $urandom_range(0, 24'hFFFFFF));
            write_reg(rrg_pkg::REG_COLOUR_B, $urandom_range(0, 24'hFFFFFF));
            if ($urandom_range(0, 5) == 0)
                load_area($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 63), $urandom_range(0, 7));
            else
                load_area($urandom_range(0, 60), $urandom_range(0, 200),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 63), $urandom_range(1, 4));
            h = (shadow_cfg.area_bottom > shadow_cfg.area_top) ?
                (shadow_cfg.area_bottom - shadow_cfg.area_top) << rrg_pkg::CELL_SHIFT : 8;
            nrows = 47;
            if (ph == 3) rx_hold = 1'b1;
            for (int k = 0; k < nrows; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_row($urandom_range(0, 2047), ph != 3);
                else if ($urandom_range(0, 3) == 0)
                    send_row((k & 1) ? h - 1 - $urandom_range(0, 63) % h
                                     : $urandom_range(0, 63) % h, ph != 3);
                else
                    send_row($urandom_range(0, h - 1), ph != 3);
            end
            drain();
        end
    endtask

    // receiver: random stall, with one long hold-off on request
    initial begin
        int g;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                rx_hold = 1'b0;
                i_m_tready <= 1'b0;
                repeat (60) @(posedge i_clk);
            end
            g = gap_len();
            if (g == 0) i_m_tready <= 1'b1;
            else begin
                i_m_tready <= 1'b0;
                repeat (g - 1) @(posedge i_clk);
            end
        end
    end

    // compare each span against the oldest prediction
    always @(posedge i_clk) begin
        rrg_pkg::t_out want, got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.drawn      = o_m_tuser;
            got.prow       = o_m_tdata[10:0];
            got.span_start = o_m_tdata[21:11];
            got.span_end   = o_m_tdata[32:22];
            got.colour     = o_m_tdata[56:33];
            if (pending_spans.size() == 0) begin
                $display("%0t unexpected span: got %h", $time, got);
                n_errors++;
            end else begin
                want = pending_spans.pop_front();
                if (got.drawn !== want.drawn) begin
                    $display("%0t drawn: expected %0d actual %0d", $time, want.drawn, got.drawn);
                    n_errors++;
                end
                if (got.prow !== want.prow) begin
                    $display("%0t pixel_row: expected %0d actual %0d", $time, want.prow, got.prow);
                    n_errors++;
                end
                if (got.span_start !== want.span_start) begin
                    $display("%0t span_start: expected %0d actual %0d", $time,
                             want.span_start, got.span_start);
                    n_errors++;
                end
                if (got.span_end !== want.span_end) begin
                    $display("%0t span_end: expected %0d actual %0d", $time,
                             want.span_end, got.span_end);
                    n_errors++;
                end
                if (got.colour !== want.colour) begin
                    $display("%0t colour: expected %h actual %h", $time, want.colour, got.colour);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        shadow_cfg  = '0;
        n_errors    = 0;
        rx_hold     = 1'b0;
        idle_cycles = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        if (n_errors == 0 && pending_spans.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

/* sim.f */
+incdir+hdl
hdl/rrg_pkg.sv
hdl/rrg_front.sv
hdl/rrg_step.sv
hdl/rrg_back.sv
hdl/rounded_rect_gradient_span.sv
hdl/rrg_checker.sv
verif/tb.sv
